FILE: sv/tlqs_pkg.sv
// ----------------------------------------------------------------------------
// tlqs_pkg: shared types and constants of the three-level queue scheduler
// Holds the sequencer states, queue identifiers, request kinds and the
// priority codes that steer an arriving task to its queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tlqs_pkg;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } tlqs_state_t;

  typedef logic [1:0] queue_id_t;

  localparam queue_id_t Q_TOP    = 2'd0;
  localparam queue_id_t Q_BANK_A = 2'd1;
  localparam queue_id_t Q_BANK_B = 2'd2;

  localparam logic CMD_ARRIVAL = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  localparam logic [2:0] PRIO_TOP_LO = 3'd1;
  localparam logic [2:0] PRIO_TOP_HI = 3'd2;
  localparam logic [2:0] PRIO_MID_LO = 3'd3;
  localparam logic [2:0] PRIO_MID_HI = 3'd4;

  localparam int PRIO_BITS  = 3;
  localparam int SLICE_BITS = 8;
  localparam int TIME_BITS  = 32;

  localparam logic [SLICE_BITS-1:0] QUANTUM_RESET = 8'd2;

endpackage

`default_nettype wire

FILE: sv/tlqs_mem.sv
// ----------------------------------------------------------------------------
// tlqs_mem: queue entry storage
// Single write port, single read port synchronous RAM holding the entries
// of all three queues; read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module tlqs_mem #(
  parameter int DEPTH     = 48,
  parameter int ADDR_BITS = 6,
  parameter int DATA_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: sv/three_level_queue_scheduler_unit.sv
// ----------------------------------------------------------------------------
// three_level_queue_scheduler_unit: three-level queue task scheduler
// Arrival requests place tasks in a round-robin top queue or one of two FIFO
// queues by priority; tick requests run the head of the highest busy queue.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the in_ stream: in_tuser selects arrival or tick, and
// in_tdata carries task id, priority and burst. Every request yields exactly
// one result on the out_ stream, in request order.
// An arrival is answered in the cycle after acceptance. A tick first pushes a
// rotating task and reads the chosen queue head from the entry RAM, then in
// ST_RUN retires it, rotates it out or writes it back decremented; no request
// is taken in ST_RUN. The result sits in an output register; a new request
// is taken while it waits, as long as it is taken in the same cycle or the
// slot is empty. A stalled receiver therefore holds off the input after at
// most one request. The quantum register is written through cfg_wr_en and
// cfg_wr_data; the user must do so only while the block is idle, as the block
// does not enforce it. Synchronous reset empties all queues, clears the time
// and slice counters and sets the quantum to 2; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_queue_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 8,
  parameter int BURST_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic                                                   in_tvalid,
  output logic                                                        in_tready,
  // task_id, priority_req, burst
  input  wire logic [((ID_BITS+tlqs_pkg::PRIO_BITS+BURST_BITS+7)/8)*8-1:0] in_tdata,
  // cmd
  input  wire logic                                                   in_tuser,

  output logic                                                        out_tvalid,
  input  wire logic                                                   out_tready,
  // accepted, idle, run_id, run_level, finished, end_time
  output logic      [((ID_BITS+4+tlqs_pkg::TIME_BITS+7)/8)*8-1:0]     out_tdata,
  // was_tick
  output logic                                                        out_tuser,

  input  wire logic                                                   cfg_wr_en,
  input  wire logic [tlqs_pkg::SLICE_BITS-1:0]                        cfg_wr_data
);

  localparam int OUT_W = ((ID_BITS + 4 + tlqs_pkg::TIME_BITS + 7) / 8) * 8;
  localparam int EW    = ID_BITS + BURST_BITS;
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int MD    = 3 * QUEUE_DEPTH;
  localparam int AW    = $clog2(MD);
  localparam int SW    = tlqs_pkg::SLICE_BITS;
  localparam int TW    = tlqs_pkg::TIME_BITS;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] ent_addr(input tlqs_pkg::queue_id_t q,
                                             input logic [PW-1:0] idx);
    return AW'(q) * AW'(QUEUE_DEPTH) + AW'(idx);
  endfunction

  tlqs_pkg::tlqs_state_t state_r, state_nxt;

  logic [PW-1:0] head_r [3];
  logic [PW-1:0] head_nxt [3];
  logic [PW-1:0] tail_r [3];
  logic [PW-1:0] tail_nxt [3];
  logic [CW-1:0] cnt_r [3];
  logic [CW-1:0] cnt_nxt [3];

  logic                swap_r, swap_nxt;
  logic [SW-1:0]       slice_r, slice_nxt;
  logic [EW-1:0]       rot_entry_r, rot_entry_nxt;
  logic                rot_valid_r, rot_valid_nxt;
  logic [TW-1:0]       time_r, time_nxt;
  logic [SW-1:0]       quantum_r;

  tlqs_pkg::queue_id_t run_q_r, run_q_nxt;
  logic                active_r, active_nxt;
  logic                fwd_r, fwd_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;
  logic                out_user_r, out_user_nxt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [EW-1:0]       mem_rdata;

  logic                in_acc;
  tlqs_pkg::queue_id_t midq, lowq, arr_q, other_q;
  logic [ID_BITS-1:0]  in_id;
  logic [2:0]          in_prio;
  logic [BURST_BITS-1:0] in_burst;
  logic [CW:0]         arr_used;
  logic                arr_ok;
  logic [EW-1:0]       cur_entry;
  logic [BURST_BITS-1:0] cur_rem, rem_dec;
  logic [ID_BITS-1:0]  cur_id;
  logic                cur_fin;
  logic [SW-1:0]       qlim;
  logic                o_accepted, o_idle, o_level, o_fin;
  logic [ID_BITS-1:0]  o_id;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == tlqs_pkg::ST_IDLE) && (!out_valid_r || out_tready);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign in_id    = in_tdata[ID_BITS-1:0];
  assign in_prio  = in_tdata[ID_BITS +: tlqs_pkg::PRIO_BITS];
  assign in_burst = in_tdata[ID_BITS+tlqs_pkg::PRIO_BITS +: BURST_BITS];

  assign midq = swap_r ? tlqs_pkg::Q_BANK_B : tlqs_pkg::Q_BANK_A;
  assign lowq = swap_r ? tlqs_pkg::Q_BANK_A : tlqs_pkg::Q_BANK_B;
  assign arr_q = (in_prio == tlqs_pkg::PRIO_TOP_LO || in_prio == tlqs_pkg::PRIO_TOP_HI) ?
                 tlqs_pkg::Q_TOP :
                 (in_prio == tlqs_pkg::PRIO_MID_LO || in_prio == tlqs_pkg::PRIO_MID_HI) ?
                 midq : lowq;
  assign arr_used = (CW+1)'(cnt_r[arr_q]) +
                    (CW+1)'((arr_q == tlqs_pkg::Q_TOP) && rot_valid_r);
  assign arr_ok   = arr_used < (CW+1)'(QUEUE_DEPTH);

  assign other_q   = (run_q_r == tlqs_pkg::Q_BANK_A) ? tlqs_pkg::Q_BANK_B : tlqs_pkg::Q_BANK_A;
  assign cur_entry = fwd_r ? rot_entry_r : mem_rdata;
  assign cur_id    = cur_entry[ID_BITS-1:0];
  assign cur_rem   = cur_entry[EW-1:ID_BITS];
  assign rem_dec   = cur_rem - BURST_BITS'(1);
  assign cur_fin   = cur_rem <= BURST_BITS'(1);
  assign qlim      = (quantum_r == '0) ? SW'(1) : quantum_r;

  tlqs_mem #(
    .DEPTH     (MD),
    .ADDR_BITS (AW),
    .DATA_BITS (EW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlqs_pkg::ST_IDLE: begin
        if (in_acc && in_tuser == tlqs_pkg::CMD_TICK) begin
          state_nxt = tlqs_pkg::ST_RUN;
        end
      end
      tlqs_pkg::ST_RUN: begin
        state_nxt = tlqs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tlqs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    swap_nxt      = swap_r;
    slice_nxt     = slice_r;
    rot_entry_nxt = rot_entry_r;
    rot_valid_nxt = rot_valid_r;
    time_nxt      = time_r;
    run_q_nxt     = run_q_r;
    active_nxt    = active_r;
    fwd_nxt       = fwd_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;
    o_accepted    = 1'b0;
    o_idle        = 1'b0;
    o_level       = 1'b0;
    o_fin         = 1'b0;
    o_id          = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    case (state_r)
      tlqs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == tlqs_pkg::CMD_TICK) begin
            fwd_nxt    = rot_valid_r && (cnt_r[tlqs_pkg::Q_TOP] == '0);
            active_nxt = 1'b1;
            if (rot_valid_r) begin
              mem_we    = 1'b1;
              mem_waddr = ent_addr(tlqs_pkg::Q_TOP, tail_r[tlqs_pkg::Q_TOP]);
              mem_wdata = rot_entry_r;
              tail_nxt[tlqs_pkg::Q_TOP] = ptr_inc(tail_r[tlqs_pkg::Q_TOP]);
              cnt_nxt[tlqs_pkg::Q_TOP]  = cnt_r[tlqs_pkg::Q_TOP] + CW'(1);
              rot_valid_nxt = 1'b0;
            end
            if (rot_valid_r || cnt_r[tlqs_pkg::Q_TOP] != '0) begin
              run_q_nxt = tlqs_pkg::Q_TOP;
              slice_nxt = slice_r + SW'(1);
              mem_raddr = ent_addr(tlqs_pkg::Q_TOP, head_r[tlqs_pkg::Q_TOP]);
            end else if (cnt_r[midq] != '0) begin
              run_q_nxt = midq;
              mem_raddr = ent_addr(midq, head_r[midq]);
            end else if (cnt_r[lowq] != '0) begin
              swap_nxt  = !swap_r;
              run_q_nxt = lowq;
              mem_raddr = ent_addr(lowq, head_r[lowq]);
            end else begin
              active_nxt = 1'b0;
            end
            time_nxt = time_r + TW'(1);
          end else begin
            if (arr_ok) begin
              mem_we    = 1'b1;
              mem_waddr = ent_addr(arr_q, tail_r[arr_q]);
              mem_wdata = {in_burst, in_id};
              tail_nxt[arr_q] = ptr_inc(tail_r[arr_q]);
              cnt_nxt[arr_q]  = cnt_r[arr_q] + CW'(1);
            end
            o_accepted    = arr_ok;
            out_valid_nxt = 1'b1;
            out_user_nxt  = tlqs_pkg::CMD_ARRIVAL;
            out_data_nxt  = OUT_W'({time_r, o_fin, o_level, o_id, o_idle, o_accepted});
          end
        end
      end
      tlqs_pkg::ST_RUN: begin
        if (active_r) begin
          o_id    = cur_id;
          o_fin   = cur_fin;
          o_level = (run_q_r != tlqs_pkg::Q_TOP);
          if (cur_fin) begin
            head_nxt[run_q_r] = ptr_inc(head_r[run_q_r]);
            cnt_nxt[run_q_r]  = cnt_r[run_q_r] - CW'(1);
            if (run_q_r == tlqs_pkg::Q_TOP) begin
              slice_nxt = '0;
            end else if (cnt_r[run_q_r] == CW'(1) && cnt_r[other_q] != '0) begin
              swap_nxt = !swap_r;
            end
          end else if (run_q_r == tlqs_pkg::Q_TOP && slice_r >= qlim) begin
            rot_entry_nxt = {rem_dec, cur_id};
            rot_valid_nxt = 1'b1;
            head_nxt[tlqs_pkg::Q_TOP] = ptr_inc(head_r[tlqs_pkg::Q_TOP]);
            cnt_nxt[tlqs_pkg::Q_TOP]  = cnt_r[tlqs_pkg::Q_TOP] - CW'(1);
            slice_nxt = '0;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = ent_addr(run_q_r, head_r[run_q_r]);
            mem_wdata = {rem_dec, cur_id};
          end
        end else begin
          o_idle = 1'b1;
        end
        out_valid_nxt = 1'b1;
        out_user_nxt  = tlqs_pkg::CMD_TICK;
        out_data_nxt  = OUT_W'({time_r, o_fin, o_level, o_id, o_idle, o_accepted});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlqs_pkg::ST_IDLE;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      cnt_r       <= '{default: '0};
      swap_r      <= 1'b0;
      slice_r     <= '0;
      rot_entry_r <= '0;
      rot_valid_r <= 1'b0;
      time_r      <= '0;
      quantum_r   <= tlqs_pkg::QUANTUM_RESET;
      run_q_r     <= tlqs_pkg::Q_TOP;
      active_r    <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      swap_r      <= swap_nxt;
      slice_r     <= slice_nxt;
      rot_entry_r <= rot_entry_nxt;
      rot_valid_r <= rot_valid_nxt;
      time_r      <= time_nxt;
      run_q_r     <= run_q_nxt;
      active_r    <= active_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        quantum_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  a_top_room: assert property (@(posedge clk) disable iff (!rst_n)
    (CW+1)'(cnt_r[tlqs_pkg::Q_TOP]) + (CW+1)'(rot_valid_r) <= (CW+1)'(QUEUE_DEPTH))
    else $error("Top queue plus rotating task exceeds the queue depth.");

  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[tlqs_pkg::Q_BANK_A] <= CW'(QUEUE_DEPTH) && cnt_r[tlqs_pkg::Q_BANK_B] <= CW'(QUEUE_DEPTH))
    else $error("FIFO queue count exceeds the queue depth.");

  a_rotate_slice: assert property (@(posedge clk) disable iff (!rst_n)
    rot_valid_r |-> slice_r == '0)
    else $error("Slice counter not cleared while a task waits to rotate.");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == tlqs_pkg::CMD_TICK |-> ##2 out_valid_r && out_user_r)
    else $error("Tick request did not produce its result two cycles later.");

  a_arrival_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == tlqs_pkg::CMD_ARRIVAL |=> out_valid_r && !out_user_r)
    else $error("Arrival request did not produce its result.");

endmodule

`default_nettype wire
